// File: rtl/core/psws_pkg.sv
// shared types and constants of the pair spread window statistics block
`timescale 1ns / 1ps
`default_nettype none
package psws_pkg;

  localparam int DEF_SYMBOLS = 64;
  localparam int DEF_WINDOW  = 256;
  localparam int DEF_PAIRS   = 32;

  localparam int PRICE_W = 24;
  localparam int SPREAD_W = 25;
  localparam int SQR_W   = 50;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 63;
  localparam int CFG_W   = 8;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam logic [1:0] CFG_SYMBOLS  = 2'd0;
  localparam logic [1:0] CFG_LOOKBACK = 2'd1;
  localparam logic [1:0] CFG_PAIRS    = 2'd2;

  typedef struct packed {
    logic upd_we;
    logic load_we;
    logic pos_walk;
    logic walk_wr;
    logic clr_we;
    logic pair_chk;
    logic step_sp;
    logic step_sq;
    logic step_acc;
    logic acc_sub;
    logic store_we;
    logic primed;
  } cmd_t;

  typedef struct packed {
    logic touched;
    logic legs_ok;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/pair_spread_window_stats_core.sv
// top level of the pair spread window statistics block
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   op, symbol, price, slot, first/second_symbol
//  out      output     out_valid_o/out_ready_i pair_index, spread_sum, spread_square_sum, last
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// price update and pair load: accepted back to back
// commit: after the accepting cycle, a walk over all SYMBOLS that writes each touched
//   symbol's staged price into its ring; then per pair with valid legs a read, a check,
//   window steps of read, spread, square and accumulate (lookback steps on the first
//   commit after a load, 2 steps later) and a store; a pair with an invalid leg goes
//   from the check straight to its result; each result waits for out_ready_i
// after reset a clearing pass over the SYMBOLS*WINDOW ring entries (16384 by default)
//   zeroes the rings and ring positions; in_ready_o stays low during it
// one item at a time: in_ready_o is low from a commit until its last result is taken
`timescale 1ns / 1ps
`default_nettype none
module pair_spread_window_stats_core
  import psws_pkg::*;
#(
  parameter int SYMBOLS = DEF_SYMBOLS,
  parameter int WINDOW  = DEF_WINDOW,
  parameter int PAIRS   = DEF_PAIRS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [CFG_W-1:0]          cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                op_i,
  input  wire logic [5:0]                symbol_i,
  input  wire logic signed [PRICE_W-1:0] price_i,
  input  wire logic [4:0]                slot_i,
  input  wire logic [5:0]                first_symbol_i,
  input  wire logic [5:0]                second_symbol_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [4:0]                     pair_index_o,
  output logic signed [SUM_W-1:0]        spread_sum_o,
  output logic [SQ_W-1:0]                spread_square_sum_o,
  output logic                           last_o
);

  localparam int SW  = $clog2(SYMBOLS);
  localparam int BW  = $clog2(WINDOW + 2);
  localparam int RAW = $clog2(SYMBOLS * WINDOW);
  localparam int PIW = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  cmd_t           cmd;
  status_t        sts;
  logic [6:0]     sym_lim;
  logic [SW-1:0]  walk_sym;
  logic [RAW-1:0] clr_addr;
  logic [PIW-1:0] pair_sel;
  logic [BW-1:0]  back;
  logic [SUM_W-1:0] sum_raw;

  // sequencer: clearing pass, symbol walk, per pair window steps
  psws_ctrl #(
    .SYMBOLS (SYMBOLS),
    .WINDOW  (WINDOW),
    .PAIRS   (PAIRS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .symbol_i     (symbol_i),
    .slot_i       (slot_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pair_index_o (pair_index_o),
    .last_o       (last_o),
    .cmd_o        (cmd),
    .sts_i        (sts),
    .sym_lim_o    (sym_lim),
    .walk_sym_o   (walk_sym),
    .clr_addr_o   (clr_addr),
    .pair_sel_o   (pair_sel),
    .back_o       (back)
  );

  // storage and the spread arithmetic; accumulator doubles as output register
  psws_dp #(
    .SYMBOLS (SYMBOLS),
    .WINDOW  (WINDOW),
    .PAIRS   (PAIRS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sym_lim_i           (sym_lim),
    .walk_sym_i          (walk_sym),
    .clr_addr_i          (clr_addr),
    .pair_sel_i          (pair_sel),
    .back_i              (back),
    .symbol_i            (symbol_i),
    .price_i             (price_i),
    .slot_i              (slot_i),
    .first_symbol_i      (first_symbol_i),
    .second_symbol_i     (second_symbol_i),
    .spread_sum_o        (sum_raw),
    .spread_square_sum_o (spread_square_sum_o)
  );

  assign spread_sum_o = signed'(sum_raw);

`ifndef NO_ASSERTIONS
  // no item is taken while a result is pending
  a_no_accept_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while a result is pending");

  // a commit blocks the input on the next cycle
  a_commit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == OP_COMMIT)) |=> !in_ready_o)
    else $error("input ready right after a commit");

  // taking the last result of a commit frees the input
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (in_ready_o && !out_valid_o))
    else $error("block not idle after last result");
`endif

endmodule
`default_nettype wire

// File: rtl/core/psws_dp.sv
// datapath: price rings, staging, pair table, statistics store and accumulator
`timescale 1ns / 1ps
`default_nettype none
module psws_dp
  import psws_pkg::*;
#(
  parameter int SYMBOLS = DEF_SYMBOLS,
  parameter int WINDOW  = DEF_WINDOW,
  parameter int PAIRS   = DEF_PAIRS,
  localparam int SW  = $clog2(SYMBOLS),
  localparam int PW  = $clog2(WINDOW),
  localparam int BW  = $clog2(WINDOW + 2),
  localparam int RAW = $clog2(SYMBOLS * WINDOW),
  localparam int PIW = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  output status_t                         sts_o,
  input  wire logic [6:0]                 sym_lim_i,
  input  wire logic [SW-1:0]              walk_sym_i,
  input  wire logic [RAW-1:0]             clr_addr_i,
  input  wire logic [PIW-1:0]             pair_sel_i,
  input  wire logic [BW-1:0]              back_i,
  input  wire logic [5:0]                 symbol_i,
  input  wire logic signed [PRICE_W-1:0]  price_i,
  input  wire logic [4:0]                 slot_i,
  input  wire logic [5:0]                 first_symbol_i,
  input  wire logic [5:0]                 second_symbol_i,
  output logic [SUM_W-1:0]                spread_sum_o,
  output logic [SQ_W-1:0]                 spread_square_sum_o
);

  localparam int DW = $clog2(3 * WINDOW);

  logic signed [PRICE_W-1:0] ring_mem [SYMBOLS*WINDOW];
  logic [PW-1:0]             pos_mem [SYMBOLS];
  logic signed [PRICE_W-1:0] staged_mem [SYMBOLS];
  logic [11:0]               pair_mem [PAIRS];
  logic [SUM_W-1:0]          sum_mem [PAIRS];
  logic [SQ_W-1:0]           sq_mem [PAIRS];

  logic [SYMBOLS-1:0] touched_q;
  logic [PAIRS-1:0]   stat_ok_q;

  logic signed [PRICE_W-1:0] ring_a_q, ring_b_q, staged_q;
  logic [PW-1:0]             pos_a_q, pos_b_q;
  logic [11:0]               pair_q;
  logic [SUM_W-1:0]          sum_rd_q, sum_q;
  logic [SQ_W-1:0]           sq_rd_q, sq_acc_q;
  logic                      stat_ok_rd_q;
  logic signed [SPREAD_W-1:0] sp_q;
  logic [SQR_W-1:0]          sqr_q;

  logic [5:0]     leg_a, leg_b;
  logic [SW-1:0]  pos_addr_a;
  logic [RAW-1:0] raddr_a, raddr_b, waddr;
  logic [PW-1:0]  pos_next;
  logic           ring_we;
  logic signed [PRICE_W-1:0] ring_wdata;

  function automatic logic [PW-1:0] back_idx(logic [PW-1:0] pos, logic [BW-1:0] back);
    logic [DW-1:0] d;
    d = DW'(pos) + DW'(2 * WINDOW) - DW'(back);
    if (d >= DW'(2 * WINDOW)) begin
      d = d - DW'(2 * WINDOW);
    end else if (d >= DW'(WINDOW)) begin
      d = d - DW'(WINDOW);
    end
    return PW'(d);
  endfunction

  function automatic logic [RAW-1:0] ring_addr(logic [SW-1:0] s, logic [PW-1:0] idx);
    return RAW'(s) * RAW'(WINDOW) + RAW'(idx);
  endfunction

  assign leg_a = pair_q[11:6];
  assign leg_b = pair_q[5:0];
  assign sts_o.legs_ok = ({1'b0, leg_a} < sym_lim_i) && ({1'b0, leg_b} < sym_lim_i);
  assign sts_o.touched = touched_q[walk_sym_i];

  assign pos_addr_a = cmd_i.pos_walk ? walk_sym_i : SW'(leg_a);
  assign raddr_a    = ring_addr(SW'(leg_a), back_idx(pos_a_q, back_i));
  assign raddr_b    = ring_addr(SW'(leg_b), back_idx(pos_b_q, back_i));
  assign pos_next   = (pos_a_q == PW'(WINDOW - 1)) ? '0 : pos_a_q + PW'(1);
  assign ring_we    = cmd_i.clr_we || cmd_i.walk_wr;
  assign waddr      = cmd_i.clr_we ? clr_addr_i : ring_addr(walk_sym_i, pos_a_q);
  assign ring_wdata = cmd_i.clr_we ? '0 : staged_q;

  // ring storage, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[waddr] <= ring_wdata;
    end
    ring_a_q <= ring_mem[raddr_a];
    ring_b_q <= ring_mem[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we && (clr_addr_i < RAW'(SYMBOLS))) begin
      pos_mem[SW'(clr_addr_i)] <= '0;
    end else if (cmd_i.walk_wr) begin
      pos_mem[walk_sym_i] <= pos_next;
    end
    pos_a_q <= pos_mem[pos_addr_a];
    pos_b_q <= pos_mem[SW'(leg_b)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_we) begin
      staged_mem[SW'(symbol_i)] <= price_i;
    end
    staged_q <= staged_mem[walk_sym_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      pair_mem[PIW'(slot_i)] <= {first_symbol_i, second_symbol_i};
    end
    pair_q <= pair_mem[pair_sel_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      sum_mem[pair_sel_i] <= sum_q;
      sq_mem[pair_sel_i]  <= sq_acc_q;
    end
    sum_rd_q <= sum_mem[pair_sel_i];
    sq_rd_q  <= sq_mem[pair_sel_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q    <= '0;
      stat_ok_q    <= '0;
      stat_ok_rd_q <= 1'b0;
    end else begin
      if (cmd_i.upd_we) begin
        touched_q[SW'(symbol_i)] <= 1'b1;
      end else if (cmd_i.walk_wr) begin
        touched_q[walk_sym_i] <= 1'b0;
      end
      if (cmd_i.load_we) begin
        stat_ok_q <= '0;
      end else if (cmd_i.store_we) begin
        stat_ok_q[pair_sel_i] <= 1'b1;
      end
      stat_ok_rd_q <= stat_ok_q[pair_sel_i];
    end
  end

  // spread, square and accumulate, one register between each
  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_chk) begin
      if ((sts_o.legs_ok && !cmd_i.primed) || !stat_ok_rd_q) begin
        sum_q    <= '0;
        sq_acc_q <= '0;
      end else begin
        sum_q    <= sum_rd_q;
        sq_acc_q <= sq_rd_q;
      end
    end else if (cmd_i.step_acc) begin
      if (cmd_i.acc_sub) begin
        sum_q    <= sum_q - SUM_W'(sp_q);
        sq_acc_q <= sq_acc_q - SQ_W'(sqr_q);
      end else begin
        sum_q    <= sum_q + SUM_W'(sp_q);
        sq_acc_q <= sq_acc_q + SQ_W'(sqr_q);
      end
    end
    if (cmd_i.step_sp) begin
      sp_q <= SPREAD_W'(ring_a_q) - SPREAD_W'(ring_b_q);
    end
    if (cmd_i.step_sq) begin
      sqr_q <= SQR_W'(sp_q) * SQR_W'(sp_q);
    end
  end

  assign spread_sum_o        = sum_q;
  assign spread_square_sum_o = sq_acc_q;

endmodule
`default_nettype wire

// File: rtl/core/psws_ctrl.sv
// controller: configuration, clearing pass, commit walk and pair sequencing
`timescale 1ns / 1ps
`default_nettype none
module psws_ctrl
  import psws_pkg::*;
#(
  parameter int SYMBOLS = DEF_SYMBOLS,
  parameter int WINDOW  = DEF_WINDOW,
  parameter int PAIRS   = DEF_PAIRS,
  localparam int SW  = $clog2(SYMBOLS),
  localparam int BW  = $clog2(WINDOW + 2),
  localparam int RAW = $clog2(SYMBOLS * WINDOW),
  localparam int PIW = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [5:0]       symbol_i,
  input  wire logic [4:0]       slot_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [4:0]            pair_index_o,
  output logic                  last_o,
  output cmd_t                  cmd_o,
  input  wire status_t          sts_i,
  output logic [6:0]            sym_lim_o,
  output logic [SW-1:0]         walk_sym_o,
  output logic [RAW-1:0]        clr_addr_o,
  output logic [PIW-1:0]        pair_sel_o,
  output logic [BW-1:0]         back_o
);

  localparam int SYM_CAP  = (SYMBOLS > 127) ? 127 : SYMBOLS;
  localparam int PAIR_CAP = (PAIRS > 63) ? 63 : PAIRS;
  localparam int LBW      = (BW > 8) ? BW : 8;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_WALK_WR, S_PAIR_RD, S_PAIR_CHK,
    S_STEP_RD, S_STEP_SP, S_STEP_SQ, S_STEP_ACC, S_STORE, S_EMIT
  } state_e;

  state_e         state_q;
  logic [6:0]     symbols_q;
  logic [7:0]     lookback_q;
  logic [5:0]     pairs_q;
  logic [SW-1:0]  sym_q;
  logic [5:0]     p_q;
  logic [BW-1:0]  back_q;
  logic           sub_q;
  logic           primed_q;
  logic           out_valid_q;
  logic [RAW-1:0] clr_q;

  logic           accept;
  logic           upd_ok, load_ok;
  logic [5:0]     np;
  logic [BW-1:0]  lb;
  logic [LBW-1:0] lk_ext;
  logic           walk_last, pair_last;

  assign sym_lim_o = (symbols_q > 7'(SYM_CAP)) ? 7'(SYM_CAP) : symbols_q;
  assign np        = (pairs_q > 6'(PAIR_CAP)) ? 6'(PAIR_CAP) : pairs_q;
  assign lk_ext    = LBW'(lookback_q);
  assign lb        = (lookback_q == '0) ? BW'(1) :
                     ((lk_ext > LBW'(WINDOW)) ? BW'(WINDOW) : BW'(lk_ext));

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign upd_ok     = accept && (op_i == OP_UPDATE) && ({1'b0, symbol_i} < sym_lim_o);
  assign load_ok    = accept && (op_i == OP_LOAD) && ({1'b0, slot_i} < 6'(PAIR_CAP));
  assign walk_last  = (sym_q == SW'(SYMBOLS - 1));
  assign pair_last  = ((p_q + 6'd1) == np);

  always_comb begin
    cmd_o          = '0;
    cmd_o.upd_we   = upd_ok;
    cmd_o.load_we  = load_ok;
    cmd_o.pos_walk = (state_q == S_WALK) || (state_q == S_WALK_WR);
    cmd_o.walk_wr  = (state_q == S_WALK_WR);
    cmd_o.clr_we   = (state_q == S_CLEAR);
    cmd_o.pair_chk = (state_q == S_PAIR_CHK);
    cmd_o.step_sp  = (state_q == S_STEP_SP);
    cmd_o.step_sq  = (state_q == S_STEP_SQ);
    cmd_o.step_acc = (state_q == S_STEP_ACC);
    cmd_o.acc_sub  = sub_q;
    cmd_o.store_we = (state_q == S_STORE);
    cmd_o.primed   = primed_q;
  end

  assign walk_sym_o   = sym_q;
  assign clr_addr_o   = clr_q;
  assign pair_sel_o   = PIW'(p_q);
  assign back_o       = back_q;
  assign out_valid_o  = out_valid_q;
  assign pair_index_o = p_q[4:0];
  assign last_o       = pair_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      symbols_q   <= 7'd64;
      lookback_q  <= 8'd32;
      pairs_q     <= 6'd0;
      sym_q       <= '0;
      p_q         <= '0;
      back_q      <= '0;
      sub_q       <= 1'b0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SYMBOLS:  symbols_q  <= cfg_data_i[6:0];
          CFG_LOOKBACK: lookback_q <= cfg_data_i;
          CFG_PAIRS:    pairs_q    <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + RAW'(1);
          if (clr_q == RAW'(SYMBOLS * WINDOW - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (load_ok) begin
            primed_q <= 1'b0;
          end
          if (accept && (op_i == OP_COMMIT)) begin
            sym_q   <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK, S_WALK_WR: begin
          if ((state_q == S_WALK) && sts_i.touched) begin
            state_q <= S_WALK_WR;
          end else if (walk_last) begin
            p_q     <= '0;
            state_q <= (np == '0) ? S_IDLE : S_PAIR_RD;
          end else begin
            sym_q   <= sym_q + SW'(1);
            state_q <= S_WALK;
          end
        end
        S_PAIR_RD: state_q <= S_PAIR_CHK;
        S_PAIR_CHK: begin
          back_q <= BW'(1);
          sub_q  <= 1'b0;
          if (sts_i.legs_ok) begin
            state_q <= S_STEP_RD;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_EMIT;
          end
        end
        S_STEP_RD: state_q <= S_STEP_SP;
        S_STEP_SP: state_q <= S_STEP_SQ;
        S_STEP_SQ: state_q <= S_STEP_ACC;
        S_STEP_ACC: begin
          if (primed_q) begin
            if (!sub_q) begin
              sub_q   <= 1'b1;
              back_q  <= lb + BW'(1);
              state_q <= S_STEP_RD;
            end else begin
              state_q <= S_STORE;
            end
          end else if (back_q == lb) begin
            state_q <= S_STORE;
          end else begin
            back_q  <= back_q + BW'(1);
            state_q <= S_STEP_RD;
          end
        end
        S_STORE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (pair_last) begin
              primed_q <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              p_q     <= p_q + 6'd1;
              state_q <= S_PAIR_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: dv/tb.sv
// self-checking testbench of the pair spread window statistics block
`timescale 1ns / 1ps

// predicted pair statistics of one result item
typedef struct {
  bit [4:0]  pair_no;
  bit [39:0] sum;
  bit [62:0] sq_sum;
  bit        last;
} pair_stats_t;

// tracks price rings, staged prices and pair statistics, predicts commit results
class pair_stats_board;
  bit signed [23:0] ring [64][256];
  bit [7:0]         ring_pos [64];
  bit signed [23:0] staged [64];
  bit               touched [64];
  bit [5:0]         leg_a [32];
  bit [5:0]         leg_b [32];
  bit [39:0]        sum_st [32];
  bit [62:0]        sq_st [32];
  bit               primed;
  bit [6:0]         n_symbols;
  bit [7:0]         lookback;
  bit [5:0]         n_pairs;
  pair_stats_t      pending [$];
  int               mismatches;
  int               results_seen;
  int               commits;

  function new();
    n_symbols = 7'd64;
    lookback  = 8'd32;
    n_pairs   = 6'd0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [7:0] data);
    case (idx)
      psws_pkg::CFG_SYMBOLS:  n_symbols = data[6:0];
      psws_pkg::CFG_LOOKBACK: lookback  = data;
      psws_pkg::CFG_PAIRS:    n_pairs   = data[5:0];
      default: ;
    endcase
  endfunction

  function longint price_back(int s, int back);
    return ring[s][(int'(ring_pos[s]) + 512 - back) % 256];
  endfunction

  function void note_item(bit [1:0] op, bit [5:0] sym, bit signed [23:0] price,
                          bit [4:0] slot, bit [5:0] fa, bit [5:0] fb);
    int lim, np, lb, a, b;
    longint sn, so;
    pair_stats_t r;
    lim = (n_symbols > 64) ? 64 : n_symbols;
    if (op == psws_pkg::OP_UPDATE) begin
      if (sym < lim) begin
        staged[sym]  = price;
        touched[sym] = 1'b1;
      end
    end else if (op == psws_pkg::OP_LOAD) begin
      leg_a[slot] = fa;
      leg_b[slot] = fb;
      for (int p = 0; p < 32; p++) begin
        sum_st[p] = '0;
        sq_st[p]  = '0;
      end
      primed = 1'b0;
    end else if (op == psws_pkg::OP_COMMIT) begin
      commits++;
      for (int s = 0; s < 64; s++) begin
        if (touched[s]) begin
          ring[s][ring_pos[s]] = staged[s];
          ring_pos[s]++;
          touched[s] = 1'b0;
        end
      end
      np = (n_pairs > 32) ? 32 : n_pairs;
      if (np == 0) return;
      lb = (lookback == 0) ? 1 : lookback;
      for (int p = 0; p < np; p++) begin
        a = leg_a[p];
        b = leg_b[p];
        if (a >= lim || b >= lim) continue;
        if (!primed) begin
          sum_st[p] = '0;
          sq_st[p]  = '0;
          for (int k = 1; k <= lb; k++) begin
            sn = price_back(a, k) - price_back(b, k);
            sum_st[p] += 40'(sn);
            sq_st[p]  += 63'(sn * sn);
          end
        end else begin
          // add the newest spread, drop the one leaving the window
          sn = price_back(a, 1) - price_back(b, 1);
          so = price_back(a, 1 + lb) - price_back(b, 1 + lb);
          sum_st[p] = sum_st[p] + 40'(sn) - 40'(so);
          sq_st[p]  = sq_st[p] + 63'(sn * sn) - 63'(so * so);
        end
      end
      primed = 1'b1;
      for (int p = 0; p < np; p++) begin
        r.pair_no = p[4:0];
        r.sum     = sum_st[p];
        r.sq_sum  = sq_st[p];
        r.last    = (p + 1 == np);
        pending.insert(pending.size(), r);
      end
    end
  endfunction

  function void check_result(logic [4:0] idx, logic [39:0] sum, logic [62:0] sq,
                             logic last);
    pair_stats_t e;
    results_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result item: pair %0d sum %h sq %h last %b",
                 idx, sum, sq, last);
      return;
    end
    e = pending.pop_front();
    if (idx !== e.pair_no || sum !== e.sum || sq !== e.sq_sum || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp pair %0d sum %h sq %h last %b / got pair %0d sum %h sq %h last %b",
                 e.pair_no, e.sum, e.sq_sum, e.last, idx, sum, sq, last);
    end
  endfunction
endclass

module tb;
  import psws_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, block ignores it

  // idling styles of the phases
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i = '0;
  logic [5:0]        symbol_i = '0;
  logic signed [PRICE_W-1:0] price_i = '0;
  logic [4:0]        slot_i = '0;
  logic [5:0]        first_symbol_i = '0;
  logic [5:0]        second_symbol_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [4:0]        pair_index_o;
  logic signed [SUM_W-1:0] spread_sum_o;
  logic [SQ_W-1:0]   spread_square_sum_o;
  logic              last_o;

  pair_stats_board board = new();
  int idle_mode = IDLE_NONE;
  int items_sent = 0;

  pair_spread_window_stats_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .symbol_i, .price_i, .slot_i,
    .first_symbol_i, .second_symbol_i,
    .out_valid_o, .out_ready_i, .pair_index_o, .spread_sum_o,
    .spread_square_sum_o, .last_o
  );

  always #6 clk_i = ~clk_i;

  // receiver back-pressure, depends on the phase
  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: out_ready_i <= ($urandom_range(99) >= 57);
      IDLE_BOTH: out_ready_i <= ($urandom_range(99) >= 7);
      default:   out_ready_i <= 1'b1;
    endcase
  end

  // every taken result item goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(pair_index_o, spread_sum_o, spread_square_sum_o, last_o);
  end

  // hard stop well beyond the slowest legal run, clearing pass included
  initial begin
    #(64'd4_000_000 * 12);
    $display("*** FAILED ***");
    $finish;
  end

  // one input item; the sender idles cycle by cycle at the phase's rate first
  task automatic send_item(logic [1:0] op, logic [5:0] sym, logic [23:0] price,
                           logic [4:0] slot, logic [5:0] fa, logic [5:0] fb);
    int p_idle;
    p_idle = 0;
    if (idle_mode == IDLE_SEND) p_idle = 57;
    if (idle_mode == IDLE_BOTH) p_idle = 7;
    while ($urandom_range(99) < p_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    symbol_i        <= sym;
    price_i         <= price;
    slot_i          <= slot;
    first_symbol_i  <= fa;
    second_symbol_i <= fb;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, sym, price, slot, fa, fb);
    items_sent++;
  endtask

  task automatic send_update(logic [5:0] sym, logic [23:0] price);
    send_item(OP_UPDATE, sym, price, 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic send_commit();
    send_item(OP_COMMIT, 6'($urandom), 24'($urandom), 5'($urandom), 6'($urandom),
              6'($urandom));
  endtask

  task automatic send_load(logic [4:0] slot, logic [5:0] fa, logic [5:0] fb);
    send_item(OP_LOAD, 6'($urandom), 24'($urandom), slot, fa, fb);
  endtask

  // drain all results, then let a result-free commit walk finish
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] symbols, logic [7:0] lookback, logic [7:0] pairs,
                            int mode);
    logic [7:0] vals [3];
    vals = '{symbols, lookback, pairs};
    wait_quiet();
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= i[1:0];
      cfg_data_i  <= vals[i];
      board.write_reg(i[1:0], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    idle_mode <= mode;
    @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_symbol(int lim);
    // mostly live symbols, sometimes any code so the ignore path runs too
    if ($urandom_range(99) < 88) return 6'($urandom_range(lim - 1));
    return 6'($urandom);
  endfunction

  function automatic logic [23:0] pick_price();
    case ($urandom_range(9))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(200)) - 24'd100;
      default: return 24'($urandom);
    endcase
  endfunction

  // batches of updates closed by a commit, with rare loads and junk opcodes
  task automatic random_traffic(int n);
    int lim, stop, k;
    lim  = (board.n_symbols > 64) ? 64 : board.n_symbols;
    stop = items_sent + n;
    while (items_sent < stop) begin
      k = $urandom_range(99);
      if (k < 4) begin
        send_load(5'($urandom), pick_symbol(lim), pick_symbol(lim));
      end else if (k < 7) begin
        send_item(OP_NONE, 6'($urandom), 24'($urandom), 5'($urandom), 6'($urandom),
                  6'($urandom));
      end else begin
        repeat ($urandom_range(0, 6)) send_update(pick_symbol(lim), pick_price());
        send_commit();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fill the pair table, extreme prices, repeated update, junk opcode
    set_config(8'd64, 8'd32, 8'd4, IDLE_NONE);
    send_load(5'd0, 6'd63, 6'd0);
    send_load(5'd1, 6'd0, 6'd63);
    send_load(5'd2, 6'd7, 6'd7);
    for (int s = 3; s < 32; s++) send_load(5'(s), 6'($urandom), 6'($urandom));
    send_update(6'd0, 24'h7fffff);
    send_update(6'd63, 24'h800000);
    send_update(6'd7, 24'd100);
    send_update(6'd7, 24'hfffffb);
    send_item(OP_NONE, 6'd1, 24'd1, 5'd1, 6'd1, 6'd1);
    send_commit();
    send_update(6'd63, 24'h7fffff);
    send_update(6'd0, 24'h800000);
    send_commit();
    send_commit();
    send_load(5'd31, 6'd63, 6'd1);
    send_commit();
    send_update(6'd1, 24'h800000);
    send_commit();

    // settings sweep, extremes included (127 symbols clamps, lookback 0 acts as 1)
    set_config(8'd64, 8'd255, 8'd2, IDLE_SEND);
    random_traffic(45);
    set_config(8'd1, 8'd0, 8'd3, IDLE_RECV);
    random_traffic(35);
    set_config(8'd127, 8'd5, 8'd32, IDLE_BOTH);
    random_traffic(45);
    set_config(8'd40, 8'd8, 8'd63, IDLE_NONE);
    random_traffic(35);
    set_config(8'd17, 8'd3, 8'd0, IDLE_SEND);
    random_traffic(25);

    wait_quiet();
    $display("run: %0d items in, %0d commits, %0d pair results checked",
             items_sent, board.commits, board.results_seen);
    $display("covered symbol counts 1..64, lookback 0..255, pair counts 0..63");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failing result items", board.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
